// File: rtl/pwct_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-width code transmitter package
// Shared widths, register indexes, reset values and phase codes.
// ----------------------------------------------------------------------------
package pwct_pkg;

    localparam int CODE_BITS_DEF = 31;

    localparam int CODE_W  = 31;
    localparam int LEAD_W  = 8;
    localparam int PART_W  = 6;
    localparam int TAIL_W  = 8;
    localparam int IDLE_W  = 10;
    localparam int TICK_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 31;
    localparam int IDX_W   = 5;

    localparam logic [ADDR_W-1:0] REG_OPEN_CODE   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_CLOSE_CODE  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_LEAD_TICKS  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LONG_TICKS  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_SHORT_TICKS = 3'd4;
    localparam logic [ADDR_W-1:0] REG_TAIL_TICKS  = 3'd5;
    localparam logic [ADDR_W-1:0] REG_IDLE_LIMIT  = 3'd6;

    localparam logic [CODE_W-1:0] OPEN_CODE_RST  = 31'h11634a08;
    localparam logic [CODE_W-1:0] CLOSE_CODE_RST = 31'h11634908;
    localparam logic [LEAD_W-1:0] LEAD_RST       = 8'd110;
    localparam logic [PART_W-1:0] LONG_RST       = 6'd12;
    localparam logic [PART_W-1:0] SHORT_RST      = 6'd4;
    localparam logic [TAIL_W-1:0] TAIL_RST       = 8'd10;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 10'd500;
    localparam logic [IDLE_W-1:0] IDLE_MAX       = 10'h3FF;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_HOLD = 6'b000010,
        PH_LEAD = 6'b000100,
        PH_HIGH = 6'b001000,
        PH_LOW  = 6'b010000,
        PH_TAIL = 6'b100000
    } t_phase;

    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

// File: rtl/pulse_width_code_transmitter.sv
// ----------------------------------------------------------------------------
// Pulse-width code transmitter
// Sends open/close code frames on a pin, one input request per timer tick.
// ----------------------------------------------------------------------------
// Each accepted request is one timer tick and yields exactly one result, the
// pin state after that tick. The frame sequencer advances once per request in
// a single registered pass, so one request is taken every clock cycle unless
// the output stalls, and its result appears in the output register on the
// following cycle; that register lets a new request enter while the previous
// result is being taken. Configuration writes take effect at the next tick.
module pulse_width_code_transmitter #(
    parameter int CODE_BITS = pwct_pkg::CODE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pwct_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [pwct_pkg::DATA_W-1:0] i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // Bits from low: open_request, close_request, zero fill.
    input  logic [7:0]                  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Bits from low: pin_level, pin_driven, busy_res, frame_done, zero fill.
    output logic [7:0]                  m_axis_tdata
);

    localparam int BIT_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

    logic [pwct_pkg::CODE_W-1:0] r_open_code, r_close_code;
    logic [pwct_pkg::LEAD_W-1:0] r_lead;
    logic [pwct_pkg::PART_W-1:0] r_long, r_short;
    logic [pwct_pkg::TAIL_W-1:0] r_tail;
    logic [pwct_pkg::IDLE_W-1:0] r_idle_limit;

    pwct_pkg::t_phase            r_phase, n_phase;
    logic [pwct_pkg::TICK_W-1:0] r_tick, n_tick;
    logic [BIT_W-1:0]            r_bit, n_bit;
    logic                        r_pend_open, n_pend_open;
    logic                        r_pend_close, n_pend_close;
    logic                        r_sending_close, n_sending_close;
    logic [pwct_pkg::IDLE_W-1:0] r_idle, n_idle;
    logic                        r_level, n_level;
    logic                        r_drive, n_drive;
    logic                        n_busy, n_done;

    logic                        r_out_valid;
    logic [3:0]                  r_out_data;

    logic                        accept;
    logic [31:0]                 code_ext;
    logic                        code_bit;
    logic [pwct_pkg::TICK_W-1:0] seg_len;
    logic [pwct_pkg::TICK_W-1:0] tick_inc;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_code  <= pwct_pkg::OPEN_CODE_RST;
            r_close_code <= pwct_pkg::CLOSE_CODE_RST;
            r_lead       <= pwct_pkg::LEAD_RST;
            r_long       <= pwct_pkg::LONG_RST;
            r_short      <= pwct_pkg::SHORT_RST;
            r_tail       <= pwct_pkg::TAIL_RST;
            r_idle_limit <= pwct_pkg::IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pwct_pkg::REG_OPEN_CODE:   r_open_code  <= i_cfg_data;
                pwct_pkg::REG_CLOSE_CODE:  r_close_code <= i_cfg_data;
                pwct_pkg::REG_LEAD_TICKS:  r_lead       <= i_cfg_data[pwct_pkg::LEAD_W-1:0];
                pwct_pkg::REG_LONG_TICKS:  r_long       <= i_cfg_data[pwct_pkg::PART_W-1:0];
                pwct_pkg::REG_SHORT_TICKS: r_short      <= i_cfg_data[pwct_pkg::PART_W-1:0];
                pwct_pkg::REG_TAIL_TICKS:  r_tail       <= i_cfg_data[pwct_pkg::TAIL_W-1:0];
                pwct_pkg::REG_IDLE_LIMIT:  r_idle_limit <= i_cfg_data[pwct_pkg::IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pend_open     = r_pend_open || s_axis_tdata[0];
        n_pend_close    = r_pend_close || s_axis_tdata[1];
        n_phase         = r_phase;
        n_tick          = r_tick;
        n_bit           = r_bit;
        n_sending_close = r_sending_close;
        n_idle          = r_idle;
        n_level         = r_level;
        n_drive         = r_drive;
        n_busy          = 1'b0;
        n_done          = 1'b0;
        code_ext        = 32'h0;
        code_bit        = 1'b0;
        seg_len         = '0;
        tick_inc        = '0;

        if (r_phase == pwct_pkg::PH_IDLE) begin
            if (n_pend_open || n_pend_close) begin
                n_sending_close = !n_pend_open;
                if (n_pend_open) begin
                    n_pend_open = 1'b0;
                end else begin
                    n_pend_close = 1'b0;
                end
                n_idle  = '0;
                n_drive = 1'b1;
                n_phase = pwct_pkg::PH_LEAD;
                n_tick  = '0;
            end else begin
                n_level = !r_level;
                n_phase = pwct_pkg::PH_HOLD;
            end
        end else if (r_phase == pwct_pkg::PH_HOLD) begin
            if (r_idle > r_idle_limit) begin
                n_drive = 1'b0;
            end
            if (r_idle != pwct_pkg::IDLE_MAX) begin
                n_idle = r_idle + pwct_pkg::IDLE_W'(1);
            end
            n_phase = pwct_pkg::PH_IDLE;
        end

        if (n_phase != pwct_pkg::PH_IDLE && n_phase != pwct_pkg::PH_HOLD) begin
            code_ext = {1'b0, n_sending_close ? r_close_code : r_open_code};
            code_bit = code_ext[5'(r_bit)];
            unique case (n_phase)
                pwct_pkg::PH_LEAD: seg_len = pwct_pkg::at_least_one(r_lead);
                pwct_pkg::PH_HIGH: seg_len = pwct_pkg::at_least_one(
                                       {2'b00, code_bit ? r_long : r_short});
                pwct_pkg::PH_LOW:  seg_len = pwct_pkg::at_least_one(
                                       {2'b00, code_bit ? r_short : r_long});
                default:           seg_len = pwct_pkg::at_least_one(r_tail);
            endcase
            n_busy   = 1'b1;
            n_level  = (n_phase == pwct_pkg::PH_HIGH);
            tick_inc = n_tick + pwct_pkg::TICK_W'(1);
            n_tick   = tick_inc;
            if (tick_inc >= seg_len) begin
                n_tick = '0;
                unique case (n_phase)
                    pwct_pkg::PH_LEAD: begin
                        n_bit   = BIT_W'(CODE_BITS - 1);
                        n_phase = pwct_pkg::PH_HIGH;
                    end
                    pwct_pkg::PH_HIGH: begin
                        n_phase = pwct_pkg::PH_LOW;
                    end
                    pwct_pkg::PH_LOW: begin
                        if (r_bit == '0) begin
                            n_phase = pwct_pkg::PH_TAIL;
                        end else begin
                            n_bit   = r_bit - BIT_W'(1);
                            n_phase = pwct_pkg::PH_HIGH;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_phase = pwct_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= pwct_pkg::PH_IDLE;
            r_tick          <= '0;
            r_bit           <= '0;
            r_pend_open     <= 1'b0;
            r_pend_close    <= 1'b0;
            r_sending_close <= 1'b0;
            r_idle          <= '0;
            r_level         <= 1'b0;
            r_drive         <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_phase         <= n_phase;
                r_tick          <= n_tick;
                r_bit           <= n_bit;
                r_pend_open     <= n_pend_open;
                r_pend_close    <= n_pend_close;
                r_sending_close <= n_sending_close;
                r_idle          <= n_idle;
                r_level         <= n_level;
                r_drive         <= n_drive;
                r_out_valid     <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {n_done, n_busy, n_drive, n_level};
        end
    end

endmodule
